>>> rtl/audio_peak_compressor_defines.svh
// Assertion macros used by the checker file apc_sva.sv.
`ifndef AUDIO_PEAK_COMPRESSOR_DEFINES_SVH
`define AUDIO_PEAK_COMPRESSOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define APC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("apc assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define APC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("apc assertion failed");

`endif

>>> rtl/apc_pkg.sv
package apc_pkg;

  // Width of the shared shift-add multiplier operands.
  localparam int unsigned MulBits = 17;
  localparam int unsigned CntBits = $clog2(MulBits);

  // Register indexes on the configuration port (byte address / 4).
  localparam logic [2:0] RegThreshold    = 3'd0;
  localparam logic [2:0] RegInverseRatio = 3'd1;
  localparam logic [2:0] RegAttackCoef   = 3'd2;
  localparam logic [2:0] RegReleaseCoef  = 3'd3;
  localparam logic [2:0] RegMakeupGain   = 3'd4;

  localparam logic [14:0] ThresholdRst    = 15'd3277;
  localparam logic [16:0] InverseRatioRst = 17'd16384;
  localparam logic [15:0] AttackCoefRst   = 16'd655;
  localparam logic [15:0] ReleaseCoefRst  = 16'd6554;
  localparam logic [15:0] MakeupGainRst   = 16'd6144;
  localparam logic [14:0] GainMax         = 15'h7fff;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CMP,
    ST_MUL_TGT,
    ST_TGT,
    ST_DIST,
    ST_MUL_STEP,
    ST_GAIN,
    ST_MUL_OUT,
    ST_DONE
  } apc_state_e;

endpackage

>>> rtl/audio_peak_compressor.sv
// Peak compressor for signed Q1.15 audio samples.
// Input stream: s_axis_* carries one sample per transfer. Output stream:
// m_axis_* carries the processed sample in tdata and the compressing flag in
// tuser. Parameters are to be written through the APB port only while the
// block is idle; the block itself does not enforce this. One sample is
// processed at a time; all products come from one bit-serial shift-add
// multiplier. A sample that stays at or below the threshold needs one
// product (makeup gain); a compressed sample needs three products (target,
// gain step, makeup gain).
// The output register parts the two sides: the next sample is accepted
// while a result still waits. If the receiver stalls, the finished result of
// the following sample waits in the last step until the output register
// frees, and no further sample is taken in the meantime.
// Reset empties the output register, returns the gain level to 32767 and
// loads the default configuration.
module audio_peak_compressor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] sample_out
  output logic [0:0]  m_axis_tuser,   // [0] compressing
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned MB = apc_pkg::MulBits;
  localparam int unsigned CB = apc_pkg::CntBits;

  apc_pkg::apc_state_e state_q, state_d;

  logic [14:0] thr_q;
  logic [16:0] inv_q;
  logic [15:0] atk_q;
  logic [15:0] rel_q;
  logic [15:0] mkp_q;

  logic [14:0] gain_q, gain_d;
  logic [14:0] tgt_q, tgt_d;
  logic [16:0] mag_q, mag_d;
  logic        neg_q, neg_d;
  logic        comp_q, comp_d;
  logic [2*MB-1:0] prod_q, prod_d;
  logic [MB-1:0]   mcand_q, mcand_d;
  logic [CB-1:0]   cnt_q, cnt_d;

  logic        out_valid_q, out_valid_d;
  logic [15:0] out_data_q, out_data_d;
  logic        out_comp_q, out_comp_d;

  logic [MB:0]     mul_sum;
  logic [2*MB-1:0] mul_next;
  logic            mul_last;
  logic [2*MB-1:0] prod_rnd15;
  logic [2*MB-1:0] prod_rnd11;
  logic [18:0]     tgt_sum;
  logic [14:0]     tgt_sat;
  logic            gain_above;
  logic [14:0]     gain_dist;
  logic [17:0]     step;
  logic [14:0]     step_c;
  logic [14:0]     gain_new;
  logic [21:0]     scaled;
  logic [15:0]     result;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= apc_pkg::ThresholdRst;
      inv_q <= apc_pkg::InverseRatioRst;
      atk_q <= apc_pkg::AttackCoefRst;
      rel_q <= apc_pkg::ReleaseCoefRst;
      mkp_q <= apc_pkg::MakeupGainRst;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        apc_pkg::RegThreshold:    thr_q <= pwdata[14:0];
        apc_pkg::RegInverseRatio: inv_q <= pwdata[16:0];
        apc_pkg::RegAttackCoef:   atk_q <= pwdata[15:0];
        apc_pkg::RegReleaseCoef:  rel_q <= pwdata[15:0];
        apc_pkg::RegMakeupGain:   mkp_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      apc_pkg::RegThreshold:    prdata = 32'(thr_q);
      apc_pkg::RegInverseRatio: prdata = 32'(inv_q);
      apc_pkg::RegAttackCoef:   prdata = 32'(atk_q);
      apc_pkg::RegReleaseCoef:  prdata = 32'(rel_q);
      apc_pkg::RegMakeupGain:   prdata = 32'(mkp_q);
      default:                  prdata = 32'd0;
    endcase
  end

  // One multiplier bit per cycle: add the multiplicand on a set LSB, shift right.
  assign mul_sum  = {1'b0, prod_q[2*MB-1:MB]} + (prod_q[0] ? {1'b0, mcand_q} : '0);
  assign mul_next = {mul_sum, prod_q[MB-1:1]};
  assign mul_last = (cnt_q == CB'(MB - 1));

  assign prod_rnd15 = prod_q + (2*MB)'(32768);
  assign prod_rnd11 = prod_q + (2*MB)'(2048);

  assign tgt_sum = 19'(thr_q) + 19'(prod_rnd15[2*MB-1:16]);
  assign tgt_sat = (tgt_sum > 19'(apc_pkg::GainMax)) ? apc_pkg::GainMax : tgt_sum[14:0];

  assign gain_above = gain_q > tgt_q;
  assign gain_dist  = gain_above ? (gain_q - tgt_q) : (tgt_q - gain_q);
  assign step       = prod_rnd15[33:16];
  assign step_c     = (step > 18'(gain_dist)) ? gain_dist : step[14:0];
  assign gain_new   = gain_above ? (gain_q - step_c) : (gain_q + step_c);

  assign scaled = prod_rnd11[33:12];
  always_comb begin
    if (neg_q) begin
      result = (scaled > 22'd32768) ? 16'h8000 : (16'd0 - scaled[15:0]);
    end else begin
      result = (scaled > 22'd32767) ? 16'h7fff : scaled[15:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    gain_d      = gain_q;
    tgt_d       = tgt_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    comp_d      = comp_q;
    prod_d      = prod_q;
    mcand_d     = mcand_q;
    cnt_d       = cnt_q;
    out_data_d  = out_data_q;
    out_comp_d  = out_comp_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    s_axis_tready = 1'b0;

    unique case (state_q)
      apc_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          neg_d   = s_axis_tdata[15];
          mag_d   = s_axis_tdata[15] ? (17'h10000 - {1'b0, s_axis_tdata})
                                     : {1'b0, s_axis_tdata};
          state_d = apc_pkg::ST_CMP;
        end
      end
      apc_pkg::ST_CMP: begin
        cnt_d  = '0;
        comp_d = mag_q > 17'(thr_q);
        if (mag_q > 17'(thr_q)) begin
          mcand_d = mag_q - 17'(thr_q);
          prod_d  = (2*MB)'(inv_q);
          state_d = apc_pkg::ST_MUL_TGT;
        end else begin
          mcand_d = mag_q;
          prod_d  = (2*MB)'(mkp_q);
          state_d = apc_pkg::ST_MUL_OUT;
        end
      end
      apc_pkg::ST_MUL_TGT: begin
        prod_d = mul_next;
        cnt_d  = cnt_q + CB'(1);
        if (mul_last) state_d = apc_pkg::ST_TGT;
      end
      apc_pkg::ST_TGT: begin
        tgt_d   = tgt_sat;
        state_d = apc_pkg::ST_DIST;
      end
      apc_pkg::ST_DIST: begin
        // Attack when the target lies below the magnitude, release otherwise.
        mcand_d = MB'(gain_dist);
        prod_d  = (17'(tgt_q) < mag_q) ? (2*MB)'(atk_q) : (2*MB)'(rel_q);
        cnt_d   = '0;
        state_d = apc_pkg::ST_MUL_STEP;
      end
      apc_pkg::ST_MUL_STEP: begin
        prod_d = mul_next;
        cnt_d  = cnt_q + CB'(1);
        if (mul_last) state_d = apc_pkg::ST_GAIN;
      end
      apc_pkg::ST_GAIN: begin
        gain_d  = gain_new;
        mcand_d = MB'(gain_new);
        prod_d  = (2*MB)'(mkp_q);
        cnt_d   = '0;
        state_d = apc_pkg::ST_MUL_OUT;
      end
      apc_pkg::ST_MUL_OUT: begin
        prod_d = mul_next;
        cnt_d  = cnt_q + CB'(1);
        if (mul_last) state_d = apc_pkg::ST_DONE;
      end
      apc_pkg::ST_DONE: begin
        // Hold until the output register is free or being drained.
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = result;
          out_comp_d  = comp_q;
          state_d     = apc_pkg::ST_IDLE;
        end
      end
      default: state_d = apc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= apc_pkg::ST_IDLE;
      gain_q      <= apc_pkg::GainMax;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gain_q      <= gain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q      <= tgt_d;
    mag_q      <= mag_d;
    neg_q      <= neg_d;
    comp_q     <= comp_d;
    prod_q     <= prod_d;
    mcand_q    <= mcand_d;
    cnt_q      <= cnt_d;
    out_data_q <= out_data_d;
    out_comp_q <= out_comp_d;
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_comp_q;

endmodule

>>> rtl/apc_sva.sv
`include "audio_peak_compressor_defines.svh"

module apc_sva (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  `APC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `APC_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser))
  `APC_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `APC_ASSERT_SAME(a_result_frees_input, $rose(m_axis_tvalid), s_axis_tready)

endmodule

bind audio_peak_compressor apc_sva u_apc_sva (.*);
